// File: sv/bca_pkg.sv
`timescale 1ns / 1ps
package bca_pkg;
  localparam int LINK_DEPTH  = 256;
  localparam int NUM_FILES   = 32;
  localparam int BLOCK_BYTES = 512;
  localparam int BW = $clog2(LINK_DEPTH);
  localparam int FW = $clog2(NUM_FILES);
  localparam int OW = $clog2(BLOCK_BYTES);
  localparam int LW = BW + 1;
  localparam int CW = BW + 1;

  // link entry: bit BW set means special; low bit 1 = free, 0 = end
  localparam logic [LW-1:0] LINK_FREE = {1'b1, {(BW-1){1'b1}}, 1'b1};
  localparam logic [LW-1:0] LINK_END  = {1'b1, {(BW-1){1'b1}}, 1'b0};

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_RESIZE = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_BAD    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FILE  = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIRST, S_AFIND, S_RWALK, S_RCNT, S_RFIND, S_REND,
    S_RTAIL, S_LWALK, S_DONE
  } core_state_e;
endpackage

// File: sv/bca_link_ram.sv
`timescale 1ns / 1ps
module bca_link_ram #(
  parameter int AW = 8,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: sv/block_chain_allocator_core.sv
`timescale 1ns / 1ps
// Block chain allocator. Keeps a FAT-style link table (one entry per block:
// free, end of chain, or the next block) and a file table of used flags and
// first blocks, and serves one request word at a time: allocate a file with a
// one-block chain, resize a file's chain to ceil(size / BLOCK_BYTES) blocks
// (at least one), or locate the block and offset holding a byte position.
// Every result word carries a status; an error leaves both tables untouched.
// The link table sits in one synchronous RAM (one write and one read port,
// read data in the cycle after the address) and every search or chain walk
// visits one entry per cycle, so a request takes as long as the entries it
// touches. After reset a clearing pass marks all LINK_DEPTH (256) links free
// with stall_o high. A request that fails its first checks (bad action,
// unused file, position past 256 blocks, no free file) skips the link table
// and goes straight to its result word. stall_o stays high for the whole
// request and while a result word waits under stall_i; the next word is
// taken in the cycle the result leaves.
module block_chain_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  file_index_i,
  input  logic [17:0] byte_count_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  file_result_o,
  output logic [7:0]  block_index_o,
  output logic [8:0]  block_offset_o
);
  import bca_pkg::*;

  core_state_e state_q, state_d;

  logic [NUM_FILES-1:0] used_q, used_d;
  logic [BW-1:0] first_mem [NUM_FILES];
  logic          first_we;
  logic [BW-1:0] first_rd_q;

  logic          we;
  logic [BW-1:0] wa, ra;
  logic [LW-1:0] wd, rd;

  bca_link_ram #(.AW(BW), .DW(LW)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(wa), .wdata_i(wd),
    .raddr_i(ra), .rdata_o(rd)
  );

  // working registers
  action_e       act_q, act_d;
  logic [FW-1:0] file_q, file_d;
  logic [17:0]   bytes_q, bytes_d;
  logic [BW-1:0] first_q, first_d, cur_q, cur_d, scan_q, scan_d;
  logic [CW-1:0] len_q, len_d, need_q, need_d, cnt_q, cnt_d, steps_q, steps_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    ost_q, ost_d;
  logic [FW-1:0] ofile_q, ofile_d;
  logic [BW-1:0] oblk_q, oblk_d;
  logic [OW-1:0] ooff_q, ooff_d;

  // lowest unused file
  logic [FW-1:0] free_file;
  logic          any_free_file;
  always_comb begin
    free_file = '0;
    any_free_file = 1'b0;
    for (int i = NUM_FILES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_file = FW'(i);
        any_free_file = 1'b1;
      end
    end
  end

  // blocks needed for the new size; anything past the table clamps to one more
  logic [18:0] need_raw;
  logic [CW-1:0] need_c;
  assign need_raw = ({1'b0, byte_count_i} + 19'(BLOCK_BYTES - 1)) >> OW;
  assign need_c = (need_raw == '0) ? CW'(1) :
                  (need_raw > 19'(LINK_DEPTH)) ? CW'(LINK_DEPTH + 1) : CW'(need_raw);

  logic [CW-1:0] cnt_inc, need_gap, len_inc, steps_inc;
  assign cnt_inc   = rd_free ? cnt_q + 1'b1 : cnt_q;
  assign need_gap  = need_q - len_q;
  assign len_inc   = len_q + 1'b1;
  assign steps_inc = steps_q + 1'b1;

  wire rd_free = (rd == LINK_FREE);
  wire rd_end  = (rd == LINK_END);
  wire rd_link = !rd[BW];
  wire scan_last = (scan_q == BW'(LINK_DEPTH - 1));
  wire in_fire = valid_i && !stall_o;
  wire pos_far = (byte_count_i[17:OW] >= 9'(LINK_DEPTH));
  wire pos_hit = (cnt_q == bytes_q[17:OW]);

  assign stall_o = (state_q != S_IDLE) || (ovalid_q && stall_i);

  always_ff @(posedge clk_i) begin
    if (first_we) first_mem[file_q] <= scan_q;
    first_rd_q <= first_mem[file_index_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q <= '0;
      ovalid_q <= 1'b0;
      scan_q <= '0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      ovalid_q <= ovalid_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; file_q <= file_d; bytes_q <= bytes_d;
    first_q <= first_d; cur_q <= cur_d; len_q <= len_d; need_q <= need_d;
    cnt_q <= cnt_d; steps_q <= steps_d;
    ost_q <= ost_d; ofile_q <= ofile_d; oblk_q <= oblk_d; ooff_q <= ooff_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (scan_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_ALLOC) state_d = any_free_file ? S_AFIND : S_DONE;
          else if (action_i == ACT_BAD || !used_q[file_index_i]) state_d = S_DONE;
          else if (action_i == ACT_LOCATE && pos_far) state_d = S_DONE;
          else state_d = S_FIRST;
        end
      end
      S_FIRST: state_d = (act_q == ACT_RESIZE) ? S_RWALK : S_LWALK;
      S_AFIND: if (rd_free || scan_last) state_d = S_DONE;
      S_RWALK: begin
        if (rd_free) state_d = S_DONE;
        else if (len_q >= need_q) state_d = rd_link ? S_RTAIL : S_DONE;
        else if (rd_end) state_d = S_RCNT;
        else if (!rd_link || len_q >= CW'(LINK_DEPTH)) state_d = S_DONE;
      end
      S_RCNT: if (scan_last) state_d = (cnt_inc < need_gap) ? S_DONE : S_RFIND;
      S_RFIND: begin
        if (rd_free) begin
          if (len_inc >= need_q) state_d = S_REND;
        end else if (scan_last) begin
          state_d = S_DONE;
        end
      end
      S_REND: state_d = S_DONE;
      S_RTAIL: if (!(rd_link && steps_inc < CW'(LINK_DEPTH))) state_d = S_DONE;
      S_LWALK: if (rd_free || pos_hit || !rd_link) state_d = S_DONE;
      S_DONE: if (!(ovalid_q && stall_i)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    used_d = used_q;
    act_d = act_q; file_d = file_q; bytes_d = bytes_q;
    first_d = first_q; cur_d = cur_q; scan_d = scan_q; len_d = len_q;
    need_d = need_q; cnt_d = cnt_q; steps_d = steps_q;
    ovalid_d = ovalid_q && stall_i;
    ost_d = ost_q; ofile_d = ofile_q; oblk_d = oblk_q; ooff_d = ooff_q;
    we = 1'b0; wa = cur_q; wd = LINK_FREE; ra = cur_q;
    first_we = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; wa = scan_q;
        scan_d = scan_q + 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          act_d = action_e'(action_i); file_d = file_index_i; bytes_d = byte_count_i;
          need_d = need_c; len_d = CW'(1); scan_d = '0; cnt_d = '0;
          steps_d = '0; ra = '0;
          ost_d = ST_INVALID; ofile_d = file_index_i; oblk_d = '0; ooff_d = '0;
          if (action_i == ACT_ALLOC) begin
            ofile_d = '0;
            if (!any_free_file) ost_d = ST_NO_FILE;
            else file_d = free_file;
          end
        end
      end
      S_FIRST: begin
        // first block arrives from the file table; start reading its link
        first_d = first_rd_q; cur_d = first_rd_q; ra = first_rd_q;
      end
      S_AFIND: begin
        // rd holds link[scan_q]
        if (rd_free) begin
          we = 1'b1; wa = scan_q; wd = LINK_END;
          used_d[file_q] = 1'b1;
          first_we = 1'b1;
          ost_d = ST_OK; ofile_d = file_q; oblk_d = scan_q;
        end else if (scan_last) begin
          ost_d = ST_NO_BLOCK;
        end else begin
          scan_d = scan_q + 1'b1; ra = scan_q + 1'b1;
        end
      end
      S_RWALK: begin
        // rd holds link[cur_q]; a free link means a broken chain
        if (rd_free) begin
          ost_d = ST_INVALID;
        end else if (len_q >= need_q) begin
          // cut the chain here and free the tail that hangs off it
          we = 1'b1; wa = cur_q; wd = LINK_END;
          if (rd_link) begin
            cur_d = rd[BW-1:0]; ra = rd[BW-1:0];
          end else begin
            ost_d = ST_OK; oblk_d = first_q;
          end
        end else if (rd_end) begin
          scan_d = '0; cnt_d = '0; ra = '0;
        end else if (rd_link && len_q < CW'(LINK_DEPTH)) begin
          cur_d = rd[BW-1:0]; ra = rd[BW-1:0]; len_d = len_inc;
        end
      end
      S_RCNT: begin
        cnt_d = cnt_inc;
        if (scan_last) begin
          if (cnt_inc < need_gap) ost_d = ST_NO_BLOCK;
          else begin
            scan_d = '0; ra = '0;
          end
        end else begin
          scan_d = scan_q + 1'b1; ra = scan_q + 1'b1;
        end
      end
      S_RFIND: begin
        // link the tail to each free block in turn; the search never steps
        // back, so a block just linked is not seen again
        if (rd_free) begin
          we = 1'b1; wa = cur_q; wd = {1'b0, scan_q};
          cur_d = scan_q; len_d = len_inc;
        end
        scan_d = scan_q + 1'b1; ra = scan_q + 1'b1;
      end
      S_REND: begin
        we = 1'b1; wa = cur_q; wd = LINK_END;
        ost_d = ST_OK; oblk_d = first_q;
      end
      S_RTAIL: begin
        we = 1'b1; wa = cur_q; wd = LINK_FREE;
        steps_d = steps_inc;
        if (rd_link && steps_inc < CW'(LINK_DEPTH)) begin
          cur_d = rd[BW-1:0]; ra = rd[BW-1:0];
        end else begin
          ost_d = ST_OK; oblk_d = first_q;
        end
      end
      S_LWALK: begin
        if (!rd_free) begin
          if (pos_hit) begin
            ost_d = ST_OK; oblk_d = cur_q; ooff_d = bytes_q[OW-1:0];
          end else if (rd_link) begin
            cur_d = rd[BW-1:0]; ra = rd[BW-1:0]; cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!(ovalid_q && stall_i)) ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign valid_o = ovalid_q;
  assign status_o = ost_q;
  assign file_result_o = ofile_q;
  assign block_index_o = oblk_q;
  assign block_offset_o = ooff_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(status_o))
    else $error("result word changed under stall");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> stall_o)
    else $error("word accepted while busy");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !valid_o)
    else $error("result during clearing pass");
endmodule
